// ----- hdl/pps_pkg.sv -----
// Package for the PPM (P6) stream parser: parser phases, field codes, header
// characters, error flag positions and the default size width.
// Has no dependencies.
`default_nettype none

package pps_pkg;

   localparam int DIM_BITS_DEFAULT = 16;

   typedef enum logic [3:0] {
      PH_MAGIC_P = 4'd0,
      PH_MAGIC_6 = 4'd1,
      PH_SKIP_W  = 4'd2,
      PH_CMT_W   = 4'd3,
      PH_NUM_W   = 4'd4,
      PH_SKIP_H  = 4'd5,
      PH_CMT_H   = 4'd6,
      PH_NUM_H   = 4'd7,
      PH_SKIP_R  = 4'd8,
      PH_CMT_R   = 4'd9,
      PH_NUM_R   = 4'd10,
      PH_EOL     = 4'd11,
      PH_EOL_CR  = 4'd12,
      PH_DATA    = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      FLD_W = 2'd0,
      FLD_H = 2'd1,
      FLD_R = 2'd2
   } field_type;

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_SIX   = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam int         RANGE_OK   = 255;

   localparam logic [1:0] CHAN_LAST = 2'd2;

   localparam int ERR_MAGIC = 0;
   localparam int ERR_SIZE  = 1;
   localparam int ERR_RANGE = 2;
   localparam int ERR_OVER  = 3;

   function automatic phase_type skip_phase(input field_type fld);
      case (fld)
         FLD_W:   skip_phase = PH_SKIP_W;
         FLD_H:   skip_phase = PH_SKIP_H;
         default: skip_phase = PH_SKIP_R;
      endcase
   endfunction

   function automatic phase_type cmt_phase(input field_type fld);
      case (fld)
         FLD_W:   cmt_phase = PH_CMT_W;
         FLD_H:   cmt_phase = PH_CMT_H;
         default: cmt_phase = PH_CMT_R;
      endcase
   endfunction

   function automatic phase_type num_phase(input field_type fld);
      case (fld)
         FLD_W:   num_phase = PH_NUM_W;
         FLD_H:   num_phase = PH_NUM_H;
         default: num_phase = PH_NUM_R;
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ppm_p6_stream_parser.sv -----
// PPM (P6) stream parser: one byte word in, one result word out.
// Depends on pps_pkg for phases, characters and flag positions.
// The result word of an accepted byte is registered and appears in the next cycle.
// Throughput is one byte per cycle while the output is not stalled; the single result register is the only stage.
// Synchronous active-high reset returns the parser to the magic check with all
// counters, stored header numbers and error flags cleared and no result pending.
`default_nettype none

module ppm_p6_stream_parser #(
   parameter int DIM_BITS = pps_pkg::DIM_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_input_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_pixel_value,
   output logic [1:0]       rsp_color_channel,
   output logic             rsp_image_last,
   output logic             rsp_header_done,
   output logic [15:0]      rsp_width_value,
   output logic [15:0]      rsp_height_value,
   output logic [15:0]      rsp_range_value,
   output logic             rsp_magic_error,
   output logic             rsp_size_error,
   output logic             rsp_range_error,
   output logic             rsp_overflow_error
);
   import pps_pkg::*;

   localparam int SUM_BITS = DIM_BITS + 4;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {4'b0, {DIM_BITS{1'b1}}};

   phase_type             phase_ff, phase_in;
   logic [DIM_BITS-1:0]   acc_ff, acc_in;
   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [DIM_BITS-1:0]   range_ff, range_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [1:0]            chan_ff, chan_in;
   logic [3:0]            flags_ff, flags_in;

   logic                  valid_ff;
   logic                  kind_ff, kind_in;
   logic [7:0]            pixel_ff, pixel_in;
   logic [1:0]            chan_out_ff, chan_out_in;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;

   logic                  accept;
   logic                  is_digit, is_hash, is_space;
   logic [SUM_BITS-1:0]   acc_ext, acc_sum;
   logic [DIM_BITS:0]     col_next, row_next;
   field_type             fld;
   logic                  store_go, enter_skip, check_go, eol_go, finish_go;
   logic                  consumed, data_go;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_digit = (req_input_byte >= CHAR_ZERO) && (req_input_byte <= CHAR_NINE);
   assign is_hash  = (req_input_byte == CHAR_HASH);
   assign is_space = (req_input_byte <= CHAR_SPACE);

   assign acc_ext = SUM_BITS'(acc_ff);
   assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + SUM_BITS'(req_input_byte[3:0]);

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      range_in    = range_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      chan_in     = chan_ff;
      flags_in    = flags_ff;
      kind_in     = 1'b0;
      pixel_in    = '0;
      chan_out_in = '0;
      last_in     = 1'b0;
      done_in     = 1'b0;
      fld         = FLD_W;
      store_go    = 1'b0;
      enter_skip  = 1'b0;
      check_go    = 1'b0;
      eol_go      = 1'b0;
      finish_go   = 1'b0;
      consumed    = 1'b0;
      data_go     = 1'b0;
      col_next    = '0;
      row_next    = '0;

      case (phase_ff)
         PH_MAGIC_6: begin
            if (req_input_byte != CHAR_SIX) begin
               flags_in[ERR_MAGIC] = 1'b1;
            end
            phase_in = PH_SKIP_W;
         end
         PH_SKIP_W: begin
            enter_skip = 1'b1;
            fld        = FLD_W;
         end
         PH_SKIP_H: begin
            enter_skip = 1'b1;
            fld        = FLD_H;
         end
         PH_SKIP_R: begin
            enter_skip = 1'b1;
            fld        = FLD_R;
         end
         PH_CMT_W: begin
            if (req_input_byte == CHAR_LF) begin
               phase_in = PH_SKIP_W;
            end
         end
         PH_CMT_H: begin
            if (req_input_byte == CHAR_LF) begin
               phase_in = PH_SKIP_H;
            end
         end
         PH_CMT_R: begin
            if (req_input_byte == CHAR_LF) begin
               phase_in = PH_SKIP_R;
            end
         end
         PH_NUM_W: begin
            store_go = 1'b1;
            fld      = FLD_W;
         end
         PH_NUM_H: begin
            store_go = 1'b1;
            fld      = FLD_H;
         end
         PH_NUM_R: begin
            store_go = 1'b1;
            fld      = FLD_R;
         end
         PH_EOL: begin
            eol_go = 1'b1;
         end
         PH_EOL_CR: begin
            finish_go = 1'b1;
            consumed  = (req_input_byte == CHAR_LF);
         end
         PH_DATA: begin
            data_go = 1'b1;
         end
         default: begin
            flags_in = '0;
            if (req_input_byte != CHAR_P) begin
               flags_in[ERR_MAGIC] = 1'b1;
            end
            phase_in = PH_MAGIC_6;
         end
      endcase

      // A digit extends the number; anything else ends it and is then
      // handled by the following phase in the same cycle.
      if (store_go) begin
         if (is_digit) begin
            if (acc_sum > SUM_MAX) begin
               acc_in             = {DIM_BITS{1'b1}};
               flags_in[ERR_OVER] = 1'b1;
            end else begin
               acc_in = acc_sum[DIM_BITS-1:0];
            end
         end else begin
            case (fld)
               FLD_W: begin
                  width_in   = acc_ff;
                  enter_skip = 1'b1;
                  fld        = FLD_H;
               end
               FLD_H: begin
                  height_in  = acc_ff;
                  enter_skip = 1'b1;
                  fld        = FLD_R;
               end
               default: begin
                  range_in = acc_ff;
                  check_go = 1'b1;
                  eol_go   = 1'b1;
               end
            endcase
            acc_in = '0;
         end
      end

      // A byte that is neither blank, comment start nor digit ends every
      // remaining number at once with the value zero.
      if (enter_skip) begin
         if (is_hash) begin
            phase_in = cmt_phase(fld);
         end else if (is_space) begin
            phase_in = skip_phase(fld);
         end else if (is_digit) begin
            phase_in = num_phase(fld);
            acc_in   = DIM_BITS'(req_input_byte[3:0]);
         end else begin
            if (fld == FLD_W) begin
               width_in = '0;
            end
            if (fld != FLD_R) begin
               height_in = '0;
            end
            range_in = '0;
            acc_in   = '0;
            check_go = 1'b1;
            eol_go   = 1'b1;
         end
      end

      if (check_go) begin
         if ((width_in == '0) || (height_in == '0)) begin
            flags_in[ERR_SIZE] = 1'b1;
         end
         if (range_in != DIM_BITS'(RANGE_OK)) begin
            flags_in[ERR_RANGE] = 1'b1;
         end
      end

      if (eol_go) begin
         if (req_input_byte == CHAR_LF) begin
            finish_go = 1'b1;
            consumed  = 1'b1;
         end else if (req_input_byte == CHAR_CR) begin
            phase_in = PH_EOL_CR;
         end else begin
            finish_go = 1'b1;
            consumed  = 1'b0;
         end
      end

      if (finish_go) begin
         done_in = 1'b1;
         col_in  = '0;
         row_in  = '0;
         chan_in = '0;
         if ((width_in == '0) || (height_in == '0)) begin
            last_in  = 1'b1;
            phase_in = PH_MAGIC_P;
         end else begin
            phase_in = PH_DATA;
            data_go  = !consumed;
         end
      end

      if (data_go) begin
         kind_in     = 1'b1;
         pixel_in    = req_input_byte;
         chan_out_in = chan_in;
         col_next    = {1'b0, col_in} + {{DIM_BITS{1'b0}}, 1'b1};
         row_next    = {1'b0, row_in} + {{DIM_BITS{1'b0}}, 1'b1};
         if (chan_in != CHAN_LAST) begin
            chan_in = chan_in + 2'd1;
         end else begin
            chan_in = '0;
            if (col_next >= {1'b0, width_in}) begin
               col_in = '0;
               if (row_next >= {1'b0, height_in}) begin
                  row_in   = '0;
                  last_in  = 1'b1;
                  phase_in = PH_MAGIC_P;
               end else begin
                  row_in = row_next[DIM_BITS-1:0];
               end
            end else begin
               col_in = col_next[DIM_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC_P;
         acc_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         range_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         chan_ff   <= '0;
         flags_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            width_ff  <= width_in;
            height_ff <= height_in;
            range_ff  <= range_in;
            col_ff    <= col_in;
            row_ff    <= row_in;
            chan_ff   <= chan_in;
            flags_ff  <= flags_in;
            valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= kind_in;
         pixel_ff    <= pixel_in;
         chan_out_ff <= chan_out_in;
         last_ff     <= last_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_item_kind      = kind_ff;
   assign rsp_pixel_value    = pixel_ff;
   assign rsp_color_channel  = chan_out_ff;
   assign rsp_image_last     = last_ff;
   assign rsp_header_done    = done_ff;
   assign rsp_width_value    = 16'(width_ff);
   assign rsp_height_value   = 16'(height_ff);
   assign rsp_range_value    = 16'(range_ff);
   assign rsp_magic_error    = flags_ff[ERR_MAGIC];
   assign rsp_size_error     = flags_ff[ERR_SIZE];
   assign rsp_range_error    = flags_ff[ERR_RANGE];
   assign rsp_overflow_error = flags_ff[ERR_OVER];

endmodule

`default_nettype wire
